>>> rtl/fbat_pkg.sv
// shared types and constants for the flow byte accounting table
// no dependencies; imported by every module of the block except fbat_ram

package fbat_pkg;

	localparam int FLOW_ENTRIES_DEF = 64;

	localparam logic [15:0] IPV4_TYPE = 16'h0800;
	localparam logic [7:0]  PROTO_TCP = 8'd6;
	localparam logic [7:0]  PROTO_UDP = 8'd17;

	localparam int ADDR_KEY_W = 64;
	localparam int PP_KEY_W   = 40;
	localparam int KEY_W      = ADDR_KEY_W + PP_KEY_W;
	localparam int BYTES_W    = 32;
	localparam int LEN_W      = 16;
	localparam int SLOT_W     = 6;

	typedef struct packed {
		logic [15:0] ether_type;
		logic [31:0] source_address;
		logic [31:0] target_address;
		logic [7:0]  ip_protocol;
		logic [15:0] source_port;
		logic [15:0] target_port;
		logic [15:0] frame_length;
	} hdr_t;

	typedef struct packed {
		logic              counted;
		logic              new_flow;
		logic [SLOT_W-1:0] flow_slot;
		logic [31:0]       flow_bytes;
		logic              table_full;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic load;     // take a new request into the datapath
		logic issue;    // read the entry at the scan index
		logic capture;  // remember the matching entry
		logic commit;   // update the table and load the result
	} cmd_t;

	typedef struct packed {
		logic more;     // entries left to read for this request
		logic inflight; // read data valid this cycle
		logic match;    // read data matches the key
		logic out_free; // result register can take a new result
	} status_t;

	function automatic logic [BYTES_W-1:0] add_sat(input logic [BYTES_W-1:0] a,
		input logic [LEN_W-1:0] b);
		logic [BYTES_W:0] s;
		s = {1'b0, a} + {{(BYTES_W + 1 - LEN_W){1'b0}}, b};
		return s[BYTES_W] ? {BYTES_W{1'b1}} : s[BYTES_W-1:0];
	endfunction

endpackage

>>> rtl/fbat_ram.sv
// generic simple dual-port ram, one write and one registered read port
// depends on nothing

module fbat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/fbat_ctrl.sv
// controller: sequences accept, linear scan and table update
// depends on fbat_pkg

module fbat_ctrl
	import fbat_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    hdr_valid,
	output logic    hdr_stall,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (hdr_valid) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.inflight && status.match) begin
					state_nxt = ST_UPDATE;
				end else if (!status.more && !status.inflight) begin
					state_nxt = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (status.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		hdr_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				hdr_stall = 1'b0;
				cmd.load  = hdr_valid;
			end
			ST_SCAN: begin
				cmd.capture = status.inflight && status.match;
				// stop reading once a hit shows up
				cmd.issue   = status.more && !cmd.capture;
			end
			ST_UPDATE: begin
				cmd.commit = status.out_free;
			end
			default: begin
				hdr_stall = 1'b1;
			end
		endcase
	end

endmodule

>>> rtl/fbat_dp.sv
// datapath: key register, scan pointer, flow memories and result register
// depends on fbat_pkg and fbat_ram

module fbat_dp
	import fbat_pkg::*;
#(
	parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  hdr_t    hdr,
	input  cmd_t    cmd,
	output status_t status,
	output logic    res_valid,
	input  logic    res_stall,
	output res_t    res
);

	localparam int IDX_W = $clog2(FLOW_ENTRIES);
	localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FLOW_ENTRIES);

	logic [KEY_W-1:0]   key_q;
	logic [LEN_W-1:0]   len_q;
	logic               ipv4_q;
	logic [CNT_W-1:0]   scan_idx_q;
	logic [CNT_W-1:0]   used_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic               hit_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [BYTES_W-1:0] hit_total_q;
	logic               res_valid_q;
	res_t               res_q;

	logic [KEY_W-1:0]   key_rd;
	logic [BYTES_W-1:0] tot_rd;
	logic [KEY_W-1:0]   key_in;
	logic               l4_ports;
	logic               full;
	logic               key_we;
	logic               tot_we;
	logic [IDX_W-1:0]   wr_idx;
	logic [BYTES_W-1:0] wr_total;
	logic [BYTES_W-1:0] sum;
	res_t               res_nxt;

	// ports only take part in the key for tcp and udp
	assign l4_ports = (hdr.ip_protocol == PROTO_TCP) || (hdr.ip_protocol == PROTO_UDP);
	assign key_in   = {hdr.source_address, hdr.target_address, hdr.ip_protocol,
		l4_ports ? hdr.source_port : 16'd0, l4_ports ? hdr.target_port : 16'd0};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= key_in;
			len_q <= hdr.frame_length;
		end
		rd_idx_s1 <= scan_idx_q[IDX_W-1:0];
		if (cmd.capture) begin
			hit_idx_q   <= rd_idx_s1;
			hit_total_q <= tot_rd;
		end
		if (cmd.commit) begin
			res_q <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ipv4_q      <= 1'b0;
			scan_idx_q  <= '0;
			used_q      <= '0;
			rd_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.issue;
			if (cmd.load) begin
				ipv4_q     <= (hdr.ether_type == IPV4_TYPE);
				scan_idx_q <= '0;
				hit_q      <= 1'b0;
			end else if (cmd.issue) begin
				scan_idx_q <= scan_idx_q + CNT_W'(1);
			end
			if (cmd.capture) begin
				hit_q <= 1'b1;
			end
			if (key_we) begin
				used_q <= used_q + CNT_W'(1);
			end
			if (cmd.commit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	fbat_ram #(
		.WIDTH(KEY_W),
		.DEPTH(FLOW_ENTRIES)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(wr_idx),
		.wdata(key_q),
		.raddr(scan_idx_q[IDX_W-1:0]),
		.rdata(key_rd)
	);

	fbat_ram #(
		.WIDTH(BYTES_W),
		.DEPTH(FLOW_ENTRIES)
	) u_total_ram (
		.clk  (clk),
		.we   (tot_we),
		.waddr(wr_idx),
		.wdata(wr_total),
		.raddr(scan_idx_q[IDX_W-1:0]),
		.rdata(tot_rd)
	);

	assign full     = (used_q == FULL_CNT);
	assign sum      = add_sat(hit_total_q, len_q);
	assign wr_idx   = hit_q ? hit_idx_q : used_q[IDX_W-1:0];
	assign wr_total = hit_q ? sum : {{(BYTES_W - LEN_W){1'b0}}, len_q};
	assign key_we   = cmd.commit && ipv4_q && !hit_q && !full;
	assign tot_we   = cmd.commit && ipv4_q && (hit_q || !full);

	always_comb begin
		res_nxt = '0;
		if (ipv4_q) begin
			if (hit_q) begin
				res_nxt.counted    = 1'b1;
				res_nxt.flow_slot  = SLOT_W'(hit_idx_q);
				res_nxt.flow_bytes = sum;
			end else if (full) begin
				res_nxt.table_full = 1'b1;
			end else begin
				res_nxt.counted    = 1'b1;
				res_nxt.new_flow   = 1'b1;
				res_nxt.flow_slot  = SLOT_W'(used_q[IDX_W-1:0]);
				res_nxt.flow_bytes = {{(BYTES_W - LEN_W){1'b0}}, len_q};
			end
		end
	end

	assign status.more     = ipv4_q && (scan_idx_q < used_q);
	assign status.inflight = rd_vld_s1;
	assign status.match    = (key_rd == key_q);
	assign status.out_free = !res_valid_q || !res_stall;

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTH
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= FULL_CNT)
		else $error("entry count beyond table size");

	a_read_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> scan_idx_q < used_q)
		else $error("read of an entry not yet written");

	a_commit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> res_valid_q)
		else $error("result lost at commit");

	a_new_entry: assert property (@(posedge clk) disable iff (!arst_n)
		key_we |=> used_q == $past(used_q) + CNT_W'(1))
		else $error("entry count not advanced for new flow");

	a_hit_no_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && hit_q |=> used_q == $past(used_q))
		else $error("entry allocated on a hit");
`endif

endmodule

>>> rtl/flow_byte_accounting_table.sv
// Flow byte accounting table. Each request is one parsed frame header; each
// gives exactly one result. IPv4 frames are looked up by five-tuple through a
// linear scan of the used entries, one entry read per cycle from the key
// memory. The scan stops at the first hit or after the last used entry. While
// a request is worked on the input is stalled, and the update also waits while
// the result register holds a stalled result. One request is worked on at a
// time; the result register lets the next request enter while a result waits.
// The memories need no clearing after reset: an entry count keeps unwritten
// entries from ever being read.

module flow_byte_accounting_table
	import fbat_pkg::*;
#(
	parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic hdr_valid,
	output logic hdr_stall,
	input  hdr_t hdr,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	cmd_t    cmd;
	status_t status;

	fbat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.hdr_valid(hdr_valid),
		.hdr_stall(hdr_stall),
		.status   (status),
		.cmd      (cmd)
	);

	fbat_dp #(
		.FLOW_ENTRIES(FLOW_ENTRIES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.hdr      (hdr),
		.cmd      (cmd),
		.status   (status),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

endmodule

>>> tb/fbat_account_check.sv
// checker for the flow byte accounting table: predicts each result from the accepted requests
// and compares it field by field with what the block returns; depends on rtl/fbat_pkg.sv

module fbat_account_check
	import fbat_pkg::*;
#(
	parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic hdr_valid,
	input  logic hdr_stall,
	input  hdr_t hdr,
	input  logic res_valid,
	input  logic res_stall,
	input  res_t res,
	output int   fails,
	output int   pending,
	output int   n_results,
	output int   n_new,
	output int   n_match,
	output int   n_full,
	output int   n_ignored
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [ADDR_KEY_W-1:0] flow_addr_key [FLOW_ENTRIES];
	logic [PP_KEY_W-1:0]   flow_pp_key [FLOW_ENTRIES];
	logic [BYTES_W-1:0]    flow_total [FLOW_ENTRIES];
	int                    flows_in_use;

	res_t expected_results[$];
	res_t oldest;
	int   fail_count;
	int   result_count;
	int   new_count;
	int   match_count;
	int   full_count;
	int   ignored_count;

	function automatic res_t account_frame(hdr_t h);
		res_t                  r;
		logic [15:0]           sp;
		logic [15:0]           dp;
		logic [ADDR_KEY_W-1:0] ak;
		logic [PP_KEY_W-1:0]   pk;
		logic [BYTES_W:0]      sum;
		r = '0;
		if (h.ether_type != IPV4_TYPE) begin
			ignored_count++;
			return r;
		end
		sp = h.source_port;
		dp = h.target_port;
		// ports only belong to the key for tcp and udp
		if (h.ip_protocol != PROTO_TCP && h.ip_protocol != PROTO_UDP) begin
			sp = '0;
			dp = '0;
		end
		ak = {h.source_address, h.target_address};
		pk = {h.ip_protocol, sp, dp};
		for (int i = 0; i < flows_in_use; i++) begin
			if (flow_addr_key[i] == ak && flow_pp_key[i] == pk) begin
				sum = {1'b0, flow_total[i]} + (BYTES_W + 1)'(h.frame_length);
				flow_total[i] = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
				r.counted = 1'b1;
				r.flow_slot = SLOT_W'(i);
				r.flow_bytes = flow_total[i];
				match_count++;
				return r;
			end
		end
		if (flows_in_use >= FLOW_ENTRIES) begin
			r.table_full = 1'b1;
			full_count++;
			return r;
		end
		flow_addr_key[flows_in_use] = ak;
		flow_pp_key[flows_in_use] = pk;
		flow_total[flows_in_use] = BYTES_W'(h.frame_length);
		r.counted = 1'b1;
		r.new_flow = 1'b1;
		r.flow_slot = SLOT_W'(flows_in_use);
		r.flow_bytes = BYTES_W'(h.frame_length);
		flows_in_use++;
		new_count++;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_results.delete();
			flows_in_use = 0;
			fail_count = 0;
			result_count = 0;
			new_count = 0;
			match_count = 0;
			full_count = 0;
			ignored_count = 0;
			fails <= 0;
			pending <= 0;
			n_results <= 0;
			n_new <= 0;
			n_match <= 0;
			n_full <= 0;
			n_ignored <= 0;
		end else begin
			// a result never belongs to the request accepted at the same edge
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					$error("result with no request waiting: %h", res);
					fail_count++;
				end else begin
					oldest = expected_results.pop_front();
					check_field("counted", 32'(oldest.counted), 32'(res.counted));
					check_field("new_flow", 32'(oldest.new_flow), 32'(res.new_flow));
					check_field("flow_slot", 32'(oldest.flow_slot), 32'(res.flow_slot));
					check_field("flow_bytes", oldest.flow_bytes, res.flow_bytes);
					check_field("table_full", 32'(oldest.table_full), 32'(res.table_full));
					result_count++;
				end
			end
			if (hdr_valid && !hdr_stall)
				expected_results.push_back(account_frame(hdr));
			fails <= fail_count;
			pending <= expected_results.size();
			n_results <= result_count;
			n_new <= new_count;
			n_match <= match_count;
			n_full <= full_count;
			n_ignored <= ignored_count;
		end
	end

endmodule

>>> tb/tb_flow_byte_accounting_table.sv
// top of the flow byte accounting table testbench: clock, reset, directed and random requests
// and the verdict; depends on rtl/fbat_pkg.sv, the block and tb/fbat_account_check.sv

module tb_flow_byte_accounting_table;
	timeunit 1ns;
	timeprecision 1ps;
	import fbat_pkg::*;

	localparam logic [7:0]  PROTO_ICMP  = 8'd1;
	localparam logic [15:0] ETH_IPV6    = 16'h86DD;
	localparam int          SOAK_FRAMES = 30;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic hdr_valid = 1'b0;
	logic hdr_stall;
	hdr_t hdr = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fails;
	int pending;
	int n_results;
	int n_new;
	int n_match;
	int n_full;
	int n_ignored;

	hdr_t flow_pool[$];
	hdr_t flow_a;

	always #5 clk = ~clk;

	flow_byte_accounting_table #(
		.FLOW_ENTRIES(FLOW_ENTRIES_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.hdr_valid(hdr_valid),
		.hdr_stall(hdr_stall),
		.hdr(hdr),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	fbat_account_check #(
		.FLOW_ENTRIES(FLOW_ENTRIES_DEF)
	) account_check (
		.clk(clk),
		.arst_n(arst_n),
		.hdr_valid(hdr_valid),
		.hdr_stall(hdr_stall),
		.hdr(hdr),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.fails(fails),
		.pending(pending),
		.n_results(n_results),
		.n_new(n_new),
		.n_match(n_match),
		.n_full(n_full),
		.n_ignored(n_ignored)
	);

	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	function automatic hdr_t frame(logic [15:0] et, logic [31:0] sa, logic [31:0] da,
		logic [7:0] pr, logic [15:0] sp, logic [15:0] dp, logic [15:0] len);
		hdr_t h;
		h.ether_type = et;
		h.source_address = sa;
		h.target_address = da;
		h.ip_protocol = pr;
		h.source_port = sp;
		h.target_port = dp;
		h.frame_length = len;
		return h;
	endfunction

	function automatic hdr_t fresh_tuple();
		hdr_t h;
		h = '0;
		h.ether_type = IPV4_TYPE;
		h.source_address = $urandom;
		h.target_address = $urandom;
		case ($urandom_range(4))
			0, 1: h.ip_protocol = PROTO_TCP;
			2, 3: h.ip_protocol = PROTO_UDP;
			default: h.ip_protocol = 8'($urandom);
		endcase
		h.source_port = 16'($urandom);
		h.target_port = 16'($urandom);
		return h;
	endfunction

	// most often revisits known flows; also near misses, new flows and some non-ipv4 noise
	function automatic hdr_t random_frame();
		hdr_t         h;
		int           r;
		int           bit_pos;
		logic [103:0] key;
		r = $urandom_range(99);
		if (r < 10) begin
			if (flow_pool.size() != 0 && $urandom_range(1) == 1)
				h = flow_pool[$urandom_range(flow_pool.size() - 1)];
			else
				h = fresh_tuple();
			h.ether_type = 16'($urandom);
			if (h.ether_type == IPV4_TYPE)
				h.ether_type = h.ether_type ^ 16'h0001;
		end else if (r < 55 && flow_pool.size() != 0) begin
			h = flow_pool[$urandom_range(flow_pool.size() - 1)];
			if (h.ip_protocol != PROTO_TCP && h.ip_protocol != PROTO_UDP) begin
				h.source_port = 16'($urandom);
				h.target_port = 16'($urandom);
			end
		end else if (r < 70 && flow_pool.size() != 0) begin
			h = flow_pool[$urandom_range(flow_pool.size() - 1)];
			key = {h.source_address, h.target_address, h.ip_protocol, h.source_port,
				h.target_port};
			bit_pos = $urandom_range(103);
			key[bit_pos] = ~key[bit_pos];
			{h.source_address, h.target_address, h.ip_protocol, h.source_port,
				h.target_port} = key;
			flow_pool.push_back(h);
		end else begin
			h = fresh_tuple();
			flow_pool.push_back(h);
		end
		case ($urandom_range(19))
			0: h.frame_length = 16'h0000;
			1: h.frame_length = 16'hFFFF;
			default: h.frame_length = 16'($urandom);
		endcase
		return h;
	endfunction

	task automatic send_frame(input hdr_t h);
		while ($urandom_range(99) < send_idle_pct) begin
			hdr_valid <= 1'b0;
			@(posedge clk);
		end
		hdr_valid <= 1'b1;
		hdr <= h;
		@(posedge clk);
		while (hdr_stall) @(posedge clk);
	endtask

	task automatic drain_results();
		hdr_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic random_traffic(input int ipv4_items);
		hdr_t h;
		int   sent;
		sent = 0;
		while (sent < ipv4_items) begin
			h = random_frame();
			send_frame(h);
			if (h.ether_type == IPV4_TYPE)
				sent++;
			if ($urandom_range(149) == 0)
				drain_results();
		end
	endtask

	initial begin
		send_idle_pct <= 38;
		recv_idle_pct <= 88;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// non-ipv4 requests at the extremes
		send_frame(frame(16'h0000, 32'h0, 32'h0, 8'h00, 16'h0, 16'h0, 16'h0));
		send_frame(frame(16'hFFFF, '1, '1, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_frame(frame(IPV4_TYPE ^ 16'h0001, 32'hC0A8_0001, 32'h0A00_0001, PROTO_TCP,
			16'h1234, 16'h0050, 16'd60));
		send_frame(frame(ETH_IPV6, 32'h1234_5678, 32'h9ABC_DEF0, PROTO_UDP, 16'd53,
			16'd53, 16'd90));

		// first flow, zero length, then repeated back to back at full length while alone, then lengths zero and one
		flow_a = frame(IPV4_TYPE, 32'hC0A8_0001, 32'h0A00_0001, PROTO_TCP, 16'h1234,
			16'h0050, 16'h0000);
		send_frame(flow_a);
		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		flow_a.frame_length = 16'hFFFF;
		for (int i = 0; i < SOAK_FRAMES; i++)
			send_frame(flow_a);
		flow_a.frame_length = 16'h0000;
		send_frame(flow_a);
		flow_a.frame_length = 16'h0001;
		send_frame(flow_a);
		flow_pool.push_back(flow_a);
		send_idle_pct <= 38;
		recv_idle_pct <= 88;
		drain_results();

		send_frame(frame(IPV4_TYPE, 32'h0, 32'h0, PROTO_UDP, 16'h0, 16'h0, 16'hFFFF));
		send_frame(frame(IPV4_TYPE, '1, '1, PROTO_UDP, 16'hFFFF, 16'hFFFF, 16'h0001));
		send_frame(frame(IPV4_TYPE, '1, '1, PROTO_TCP, 16'hFFFF, 16'hFFFF, 16'h0001));
		// ports do not count for other protocols, so the second request matches
		send_frame(frame(IPV4_TYPE, 32'h0A0A_0A0A, 32'h0B0B_0B0B, PROTO_ICMP, 16'h1111,
			16'h2222, 16'd64));
		send_frame(frame(IPV4_TYPE, 32'h0A0A_0A0A, 32'h0B0B_0B0B, PROTO_ICMP, 16'hFFFF,
			16'h0000, 16'd64));
		send_frame(frame(IPV4_TYPE, 32'h0A0A_0A0A, 32'h0B0B_0B0B, 8'h00, 16'h1234,
			16'h5678, 16'd1500));
		send_frame(frame(IPV4_TYPE, 32'h0A0A_0A0A, 32'h0B0B_0B0B, 8'hFF, 16'hABCD,
			16'h0001, 16'd1500));
		send_frame(frame(IPV4_TYPE, 32'hC0A8_0001, 32'h0A00_0001, PROTO_TCP, 16'h1235,
			16'h0050, 16'd40));
		send_frame(frame(IPV4_TYPE, 32'h0A00_0001, 32'hC0A8_0001, PROTO_TCP, 16'h0050,
			16'h1234, 16'd40));
		send_frame(frame(IPV4_TYPE ^ 16'h0001, 32'h0, 32'h0, PROTO_UDP, 16'h0, 16'h0,
			16'd100));
		send_frame(frame(IPV4_TYPE, '1, '1, PROTO_UDP, 16'hFFFF, 16'hFFFF, 16'hFFFF));

		random_traffic(700);
		drain_results();

		send_idle_pct <= 88;
		recv_idle_pct <= 38;
		drain_results();
		random_traffic(650);
		drain_results();

		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		drain_results();
		random_traffic(650);

		drain_results();
		repeat (FLOW_ENTRIES_DEF + 8) @(posedge clk);

		$display("checked %0d results: %0d new flows, %0d matches, %0d dropped on a full table",
			n_results, n_new, n_match, n_full);
		$display("%0d non-ipv4 frames ignored; one flow hit back to back at full length first",
			n_ignored);
		if (fails == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
